[src/boris_velocity_push_core_macros.svh]
// ---------------------------------------------------------------------------
// Boris velocity push assertion macros
// Short forms for the concurrent checks used inside the pusher core.
// ---------------------------------------------------------------------------
`ifndef BORIS_VELOCITY_PUSH_CORE_MACROS_SVH
`define BORIS_VELOCITY_PUSH_CORE_MACROS_SVH

// Checks that a consequent holds in the same cycle as its antecedent.
`define BVP_ASSERT_NOW(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) else $error(msg);

// Checks that a consequent holds in the cycle after its antecedent.
`define BVP_ASSERT_NEXT(lbl, ante, cons, msg) \
lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) else $error(msg);

`endif

[src/bvp_pkg.sv]
// ---------------------------------------------------------------------------
// Boris velocity push package
// Types and constants shared by the pusher core and its reciprocal pipeline.
// ---------------------------------------------------------------------------
`default_nettype none

package bvp_pkg;

   typedef struct packed {
      logic enable;
      logic valid;
   } pipe_ctl_type;

   localparam int unsigned CSR_HALF_QM_DT = 0;
   localparam int unsigned CSR_HALF_DT    = 1;

endpackage

`default_nettype wire

[src/bvp_if.sv]
// ---------------------------------------------------------------------------
// Boris velocity push channel interfaces
// Particle request beat and pushed particle response beat.
// ---------------------------------------------------------------------------
`default_nettype none

interface bvp_req_if #(parameter int WORD_BITS = 32);
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] vel_x;
   logic signed [WORD_BITS-1:0] vel_y;
   logic signed [WORD_BITS-1:0] vel_z;
   logic signed [WORD_BITS-1:0] field_ex;
   logic signed [WORD_BITS-1:0] field_ey;
   logic signed [WORD_BITS-1:0] field_ez;
   logic signed [WORD_BITS-1:0] field_bx;
   logic signed [WORD_BITS-1:0] field_by;
   logic signed [WORD_BITS-1:0] field_bz;

   modport source (output valid, vel_x, vel_y, vel_z, field_ex, field_ey, field_ez,
                   field_bx, field_by, field_bz, input ready);
   modport sink   (input valid, vel_x, vel_y, vel_z, field_ex, field_ey, field_ez,
                   field_bx, field_by, field_bz, output ready);
endinterface

interface bvp_rsp_if #(parameter int WORD_BITS = 32);
   logic                        valid;
   logic                        ready;
   logic signed [WORD_BITS-1:0] new_vel_x;
   logic signed [WORD_BITS-1:0] new_vel_y;
   logic signed [WORD_BITS-1:0] new_vel_z;
   logic signed [WORD_BITS-1:0] step_x;
   logic signed [WORD_BITS-1:0] step_y;
   logic signed [WORD_BITS-1:0] step_z;

   modport source (output valid, new_vel_x, new_vel_y, new_vel_z, step_x, step_y, step_z,
                   input ready);
   modport sink   (input valid, new_vel_x, new_vel_y, new_vel_z, step_x, step_y, step_z,
                   output ready);
endinterface

`default_nettype wire

[src/bvp_recip.sv]
// ---------------------------------------------------------------------------
// Boris velocity push reciprocal pipeline
// Restoring division of 2^(2F+1) by the denominator, one quotient bit per
// stage, saturated to the most positive word, with a payload carried along.
// ---------------------------------------------------------------------------
`default_nettype none

module bvp_recip #(
   parameter int WORD_BITS     = 32,
   parameter int FRACTION_BITS = 16,
   parameter int PAYLOAD_BITS  = 384
) (
   input  wire logic                        clock,
   input  wire logic                        reset,
   input  wire bvp_pkg::pipe_ctl_type       ctl,
   input  wire logic signed [WORD_BITS-1:0] den,
   input  wire logic [PAYLOAD_BITS-1:0]     payload_in,
   output logic                             valid_out,
   output logic signed [WORD_BITS-1:0]      quot,
   output logic [PAYLOAD_BITS-1:0]          payload_out
);

   localparam int W  = WORD_BITS;
   localparam int NB = 2 * FRACTION_BITS + 2;
   localparam int QW = ((NB > W) ? NB : W) + 1;
   localparam logic [QW-1:0] QMAX = QW'({1'b0, {(W-1){1'b1}}});

   logic            val_ff [NB];
   logic [W-1:0]    rem_ff [NB];
   logic [NB-1:0]   quo_ff [NB];
   logic [W-1:0]    den_ff [NB];
   logic [PAYLOAD_BITS-1:0] pay_ff [NB];

   for (genvar i = 0; i < NB; i++) begin : g_stage
      localparam logic NBIT = (i == 0);
      logic                    val_src;
      logic [W-1:0]            rem_src;
      logic [NB-1:0]           quo_src;
      logic [W-1:0]            den_src;
      logic [PAYLOAD_BITS-1:0] pay_src;
      logic [W:0]              trial;
      logic                    ge;
      logic [W-1:0]            rem_in;
      logic [NB-1:0]           quo_in;

      if (i == 0) begin : g_first
         assign val_src = ctl.valid;
         assign rem_src = '0;
         assign quo_src = '0;
         assign den_src = den;
         assign pay_src = payload_in;
      end else begin : g_rest
         assign val_src = val_ff[i-1];
         assign rem_src = rem_ff[i-1];
         assign quo_src = quo_ff[i-1];
         assign den_src = den_ff[i-1];
         assign pay_src = pay_ff[i-1];
      end

      always_comb begin
         trial  = {rem_src, NBIT};
         ge     = trial >= {1'b0, den_src};
         rem_in = ge ? W'(trial - {1'b0, den_src}) : trial[W-1:0];
         quo_in = {quo_src[NB-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            val_ff[i] <= 1'b0;
         end else if (ctl.enable) begin
            val_ff[i] <= val_src;
         end
         if (ctl.enable) begin
            rem_ff[i] <= rem_in;
            quo_ff[i] <= quo_in;
            den_ff[i] <= den_src;
            pay_ff[i] <= pay_src;
         end
      end
   end

   logic [QW-1:0] quo_ext;

   always_comb begin
      quo_ext     = QW'(quo_ff[NB-1]);
      quot        = (quo_ext > QMAX) ? W'(QMAX) : W'(quo_ext);
      valid_out   = val_ff[NB-1];
      payload_out = pay_ff[NB-1];
   end

endmodule

`default_nettype wire

[src/boris_velocity_push_core.sv]
// ---------------------------------------------------------------------------
// Boris velocity push core
// Fixed-point Boris step for one particle a beat: half electric kick,
// magnetic rotation, second half kick and the position increment.
// ---------------------------------------------------------------------------
//
//   Channel   Direction  Beat contents
//   req_chan  in         velocity, electric field, magnetic field
//   rsp_chan  out        new velocity, position increment
//   csr_*     in         half_qm_dt (index 0), half_dt (index 1)
//
// One particle is taken every cycle while the output beat is not held; the
// reciprocal pipeline yields one quotient bit per stage.
// Reset is synchronous and clears only the valid bits and the configuration registers.
// A stalled response freezes the whole pipeline; nothing is dropped or
// repeated, and req_chan.ready falls only while the output beat waits.
`default_nettype none
`include "boris_velocity_push_core_macros.svh"

module boris_velocity_push_core #(
   parameter int WORD_BITS     = 32,
   parameter int FRACTION_BITS = 16
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   bvp_req_if.sink                   req_chan,
   bvp_rsp_if.source                 rsp_chan,
   input  wire logic                 csr_wr_en,
   input  wire logic                 csr_index,
   input  wire logic [WORD_BITS-1:0] csr_wdata
);

   localparam int W  = WORD_BITS;
   localparam int F  = FRACTION_BITS;
   localparam int PB = 12 * W;
   localparam logic signed [W-1:0] WMAX = {1'b0, {(W-1){1'b1}}};
   localparam logic signed [W-1:0] WMIN = {1'b1, {(W-1){1'b0}}};
   localparam logic signed [W-1:0] ONE  = (F < W - 1) ? (W'(1) << F) : WMAX;

   function automatic logic signed [W-1:0] sat_add(input logic signed [W-1:0] a,
                                                   input logic signed [W-1:0] b);
      logic signed [W:0] s;
      s = {a[W-1], a} + {b[W-1], b};
      if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
      return s[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] sat_sub(input logic signed [W-1:0] a,
                                                   input logic signed [W-1:0] b);
      logic signed [W:0] s;
      s = {a[W-1], a} - {b[W-1], b};
      if (s[W] != s[W-1]) return s[W] ? WMIN : WMAX;
      return s[W-1:0];
   endfunction

   function automatic logic signed [W-1:0] fmul(input logic signed [W-1:0] a,
                                                input logic signed [W-1:0] b);
      logic signed [2*W-1:0] p;
      logic signed [2*W-1:0] sh;
      p  = (2*W)'(a) * (2*W)'(b);
      sh = p >>> F;
      if ((&sh[2*W-1:W-1]) || !(|sh[2*W-1:W-1])) return sh[W-1:0];
      return sh[2*W-1] ? WMIN : WMAX;
   endfunction

   // Configuration registers.
   logic signed [W-1:0] half_qm_dt_ff;
   logic [W-2:0]        half_dt_ff;
   logic signed [W-1:0] hd;

   always_ff @(posedge clock) begin
      if (reset) begin
         half_qm_dt_ff <= '0;
         half_dt_ff    <= '0;
      end else if (csr_wr_en) begin
         if (csr_index == 1'(bvp_pkg::CSR_HALF_QM_DT)) begin
            half_qm_dt_ff <= csr_wdata;
         end else begin
            half_dt_ff <= csr_wdata[W-2:0];
         end
      end
   end

   assign hd = {1'b0, half_dt_ff};

   // Pipeline advance: everything moves unless the output beat is held.
   logic out_valid_ff;
   logic adv;
   assign adv            = !out_valid_ff || rsp_chan.ready;
   assign req_chan.ready = adv;

   logic acc;
   assign acc = req_chan.valid && adv;

   logic signed [W-1:0] vin [3], ein [3], bin [3];
   assign vin[0] = req_chan.vel_x;    assign vin[1] = req_chan.vel_y;
   assign vin[2] = req_chan.vel_z;
   assign ein[0] = req_chan.field_ex; assign ein[1] = req_chan.field_ey;
   assign ein[2] = req_chan.field_ez;
   assign bin[0] = req_chan.field_bx; assign bin[1] = req_chan.field_by;
   assign bin[2] = req_chan.field_bz;

   logic val1_ff, val2_ff, val3_ff, val4_ff, val5_ff, val6_ff;
   logic val8_ff, val9_ff, val10_ff;
   logic val7;

   always_ff @(posedge clock) begin
      if (reset) begin
         val1_ff      <= 1'b0;
         val2_ff      <= 1'b0;
         val3_ff      <= 1'b0;
         val4_ff      <= 1'b0;
         val5_ff      <= 1'b0;
         val6_ff      <= 1'b0;
         val8_ff      <= 1'b0;
         val9_ff      <= 1'b0;
         val10_ff     <= 1'b0;
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         val1_ff      <= acc;
         val2_ff      <= val1_ff;
         val3_ff      <= val2_ff;
         val4_ff      <= val3_ff;
         val5_ff      <= val4_ff;
         val6_ff      <= val5_ff;
         val8_ff      <= val7;
         val9_ff      <= val8_ff;
         val10_ff     <= val9_ff;
         out_valid_ff <= val10_ff;
      end
   end

   // Stage 1: field scaling.
   logic signed [W-1:0] v1_ff [3], e1_ff [3], t1_ff [3];
   logic signed [W-1:0] e1_in [3], t1_in [3];
   // Stage 2: first half kick and squares of t.
   logic signed [W-1:0] v2_ff [3], e2_ff [3], t2_ff [3], m2_ff [3], q2_ff [3];
   logic signed [W-1:0] m2_in [3], q2_in [3];
   // Stage 3: products of m x t and the denominator.
   logic signed [W-1:0] v3_ff [3], e3_ff [3], t3_ff [3], m3_ff [3];
   logic signed [W-1:0] xa3_ff [3], xb3_ff [3], xa3_in [3], xb3_in [3];
   logic signed [W-1:0] d3_ff, d3_in;
   // Stage 4: p = m + m x t.
   logic signed [W-1:0] v4_ff [3], e4_ff [3], t4_ff [3], m4_ff [3], p4_ff [3], p4_in [3];
   logic signed [W-1:0] d4_ff;
   // Stage 5: products of p x t.
   logic signed [W-1:0] v5_ff [3], e5_ff [3], m5_ff [3];
   logic signed [W-1:0] xa5_ff [3], xb5_ff [3], xa5_in [3], xb5_in [3];
   logic signed [W-1:0] d5_ff;
   // Stage 6: c = p x t.
   logic signed [W-1:0] v6_ff [3], e6_ff [3], m6_ff [3], c6_ff [3], c6_in [3];
   logic signed [W-1:0] d6_ff;

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         e1_in[i] = fmul(ein[i], half_qm_dt_ff);
         t1_in[i] = fmul(bin[i], half_qm_dt_ff);
         m2_in[i] = sat_add(v1_ff[i], e1_ff[i]);
         q2_in[i] = fmul(t1_ff[i], t1_ff[i]);
         p4_in[i] = sat_add(m3_ff[i], sat_sub(xa3_ff[i], xb3_ff[i]));
         c6_in[i] = sat_sub(xa5_ff[i], xb5_ff[i]);
      end
      xa3_in[0] = fmul(m2_ff[1], t2_ff[2]);  xb3_in[0] = fmul(m2_ff[2], t2_ff[1]);
      xa3_in[1] = fmul(m2_ff[2], t2_ff[0]);  xb3_in[1] = fmul(m2_ff[0], t2_ff[2]);
      xa3_in[2] = fmul(m2_ff[0], t2_ff[1]);  xb3_in[2] = fmul(m2_ff[1], t2_ff[0]);
      d3_in     = sat_add(sat_add(sat_add(q2_ff[0], q2_ff[1]), q2_ff[2]), ONE);
      xa5_in[0] = fmul(p4_ff[1], t4_ff[2]);  xb5_in[0] = fmul(p4_ff[2], t4_ff[1]);
      xa5_in[1] = fmul(p4_ff[2], t4_ff[0]);  xb5_in[1] = fmul(p4_ff[0], t4_ff[2]);
      xa5_in[2] = fmul(p4_ff[0], t4_ff[1]);  xb5_in[2] = fmul(p4_ff[1], t4_ff[0]);
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            v1_ff[i]  <= vin[i];
            e1_ff[i]  <= e1_in[i];
            t1_ff[i]  <= t1_in[i];
            v2_ff[i]  <= v1_ff[i];
            e2_ff[i]  <= e1_ff[i];
            t2_ff[i]  <= t1_ff[i];
            m2_ff[i]  <= m2_in[i];
            q2_ff[i]  <= q2_in[i];
            v3_ff[i]  <= v2_ff[i];
            e3_ff[i]  <= e2_ff[i];
            t3_ff[i]  <= t2_ff[i];
            m3_ff[i]  <= m2_ff[i];
            xa3_ff[i] <= xa3_in[i];
            xb3_ff[i] <= xb3_in[i];
            v4_ff[i]  <= v3_ff[i];
            e4_ff[i]  <= e3_ff[i];
            t4_ff[i]  <= t3_ff[i];
            m4_ff[i]  <= m3_ff[i];
            p4_ff[i]  <= p4_in[i];
            v5_ff[i]  <= v4_ff[i];
            e5_ff[i]  <= e4_ff[i];
            m5_ff[i]  <= m4_ff[i];
            xa5_ff[i] <= xa5_in[i];
            xb5_ff[i] <= xb5_in[i];
            v6_ff[i]  <= v5_ff[i];
            e6_ff[i]  <= e5_ff[i];
            m6_ff[i]  <= m5_ff[i];
            c6_ff[i]  <= c6_in[i];
         end
         d3_ff <= d3_in;
         d4_ff <= d3_ff;
         d5_ff <= d4_ff;
         d6_ff <= d5_ff;
      end
   end

   // Rotation scale s = 2 / (1 + |t|^2).
   bvp_pkg::pipe_ctl_type div_ctl;
   logic [PB-1:0]         pay6, pay7;
   logic signed [W-1:0]   s7;

   assign div_ctl.enable = adv;
   assign div_ctl.valid  = val6_ff;
   assign pay6 = {v6_ff[0], v6_ff[1], v6_ff[2], e6_ff[0], e6_ff[1], e6_ff[2],
                  m6_ff[0], m6_ff[1], m6_ff[2], c6_ff[0], c6_ff[1], c6_ff[2]};

   bvp_recip #(
      .WORD_BITS     (W),
      .FRACTION_BITS (F),
      .PAYLOAD_BITS  (PB)
   ) u_recip (
      .clock       (clock),
      .reset       (reset),
      .ctl         (div_ctl),
      .den         (d6_ff),
      .payload_in  (pay6),
      .valid_out   (val7),
      .quot        (s7),
      .payload_out (pay7)
   );

   logic signed [W-1:0] v7 [3], e7 [3], m7 [3], c7 [3];
   always_comb begin
      for (int i = 0; i < 3; i++) begin
         v7[i] = pay7[PB-1-i*W -: W];
         e7[i] = pay7[PB-1-(3+i)*W -: W];
         m7[i] = pay7[PB-1-(6+i)*W -: W];
         c7[i] = pay7[PB-1-(9+i)*W -: W];
      end
   end

   // Stages 8 to 10 and the output register.
   logic signed [W-1:0] v8_ff [3], e8_ff [3], m8_ff [3], cs8_ff [3], cs8_in [3];
   logic signed [W-1:0] v9_ff [3], nv9_ff [3], nv9_in [3];
   logic signed [W-1:0] nv10_ff [3], a10_ff [3], b10_ff [3], a10_in [3], b10_in [3];
   logic signed [W-1:0] nv_out_ff [3], st_out_ff [3], st_out_in [3];

   always_comb begin
      for (int i = 0; i < 3; i++) begin
         cs8_in[i]    = fmul(c7[i], s7);
         nv9_in[i]    = sat_add(sat_add(m8_ff[i], cs8_ff[i]), e8_ff[i]);
         a10_in[i]    = fmul(v9_ff[i], hd);
         b10_in[i]    = fmul(nv9_ff[i], hd);
         st_out_in[i] = sat_add(a10_ff[i], b10_ff[i]);
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         for (int i = 0; i < 3; i++) begin
            v8_ff[i]     <= v7[i];
            e8_ff[i]     <= e7[i];
            m8_ff[i]     <= m7[i];
            cs8_ff[i]    <= cs8_in[i];
            v9_ff[i]     <= v8_ff[i];
            nv9_ff[i]    <= nv9_in[i];
            nv10_ff[i]   <= nv9_ff[i];
            a10_ff[i]    <= a10_in[i];
            b10_ff[i]    <= b10_in[i];
            nv_out_ff[i] <= nv10_ff[i];
            st_out_ff[i] <= st_out_in[i];
         end
      end
   end

   assign rsp_chan.valid     = out_valid_ff;
   assign rsp_chan.new_vel_x = nv_out_ff[0];
   assign rsp_chan.new_vel_y = nv_out_ff[1];
   assign rsp_chan.new_vel_z = nv_out_ff[2];
   assign rsp_chan.step_x    = st_out_ff[0];
   assign rsp_chan.step_y    = st_out_ff[1];
   assign rsp_chan.step_z    = st_out_ff[2];

   `BVP_ASSERT_NOW(a_den_positive, val4_ff, !d4_ff[W-1] && d4_ff != '0, "denominator not positive")
   `BVP_ASSERT_NOW(a_scale_nonneg, val7, !s7[W-1], "rotation scale negative")
   `BVP_ASSERT_NEXT(a_stall_holds, !adv, val6_ff == $past(val6_ff) && val10_ff == $past(val10_ff), "pipeline moved while stalled")

endmodule

`default_nettype wire

[dv/testbench.sv]
// ---------------------------------------------------------------------------
// Boris velocity push core testbench
// Streams particles through the pusher under several register settings. A
// scoreboard predicts each pushed particle and checks every response beat.
// ---------------------------------------------------------------------------
`default_nettype none

module testbench;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int     WORD_BITS     = 32;
   localparam int     FRACTION_BITS = 16;
   localparam longint WORD_MAX      = 64'sd2147483647;
   localparam longint WORD_MIN      = -64'sd2147483648;
   localparam int     LATENCY       = 2 * FRACTION_BITS + 12;

   typedef logic signed [WORD_BITS-1:0] word_type;

   typedef struct packed {
      word_type vx, vy, vz, ex, ey, ez, bx, by, bz;
   } particle_type;

   typedef struct packed {
      word_type nvx, nvy, nvz, sx, sy, sz;
   } pushed_type;

   class push_scoreboard;
      longint     qm_dt;
      longint     half_dt;
      pushed_type pending[$];
      int         errors;

      function new();
         qm_dt   = 0;
         half_dt = 0;
         errors  = 0;
      endfunction

      function longint sat(longint x);
         if (x > WORD_MAX) return WORD_MAX;
         if (x < WORD_MIN) return WORD_MIN;
         return x;
      endfunction

      function longint fx_mul(longint a, longint b);
         longint p;
         p = a * b;
         return sat(p >>> FRACTION_BITS);
      endfunction

      function longint fx_scale(longint d);
         if (d <= 0) return WORD_MAX;
         return sat((64'sd1 <<< (2 * FRACTION_BITS + 1)) / d);
      endfunction

      function void set_reg(int unsigned idx, logic [WORD_BITS-1:0] data);
         if (idx == bvp_pkg::CSR_HALF_QM_DT) qm_dt = longint'(signed'(data));
         else if (idx == bvp_pkg::CSR_HALF_DT) half_dt = longint'(data[WORD_BITS-2:0]);
      endfunction

      function void note_particle(particle_type pt);
         longint     v[3], e[3], t[3], m[3], p[3], c[3], nv[3], st[3];
         longint     tt, s;
         pushed_type r;
         v[0] = pt.vx; v[1] = pt.vy; v[2] = pt.vz;
         e[0] = fx_mul(pt.ex, qm_dt); e[1] = fx_mul(pt.ey, qm_dt);
         e[2] = fx_mul(pt.ez, qm_dt);
         t[0] = fx_mul(pt.bx, qm_dt); t[1] = fx_mul(pt.by, qm_dt);
         t[2] = fx_mul(pt.bz, qm_dt);
         for (int i = 0; i < 3; i++) m[i] = sat(v[i] + e[i]);
         c[0] = sat(fx_mul(m[1], t[2]) - fx_mul(m[2], t[1]));
         c[1] = sat(fx_mul(m[2], t[0]) - fx_mul(m[0], t[2]));
         c[2] = sat(fx_mul(m[0], t[1]) - fx_mul(m[1], t[0]));
         for (int i = 0; i < 3; i++) p[i] = sat(m[i] + c[i]);
         tt = sat(sat(fx_mul(t[0], t[0]) + fx_mul(t[1], t[1])) + fx_mul(t[2], t[2]));
         s  = fx_scale(sat(tt + (64'sd1 <<< FRACTION_BITS)));
         c[0] = sat(fx_mul(p[1], t[2]) - fx_mul(p[2], t[1]));
         c[1] = sat(fx_mul(p[2], t[0]) - fx_mul(p[0], t[2]));
         c[2] = sat(fx_mul(p[0], t[1]) - fx_mul(p[1], t[0]));
         for (int i = 0; i < 3; i++) begin
            nv[i] = sat(sat(m[i] + fx_mul(c[i], s)) + e[i]);
            st[i] = sat(fx_mul(v[i], half_dt) + fx_mul(nv[i], half_dt));
         end
         r.nvx = nv[0][WORD_BITS-1:0]; r.nvy = nv[1][WORD_BITS-1:0];
         r.nvz = nv[2][WORD_BITS-1:0];
         r.sx  = st[0][WORD_BITS-1:0]; r.sy  = st[1][WORD_BITS-1:0];
         r.sz  = st[2][WORD_BITS-1:0];
         pending.push_back(r);
      endfunction

      function void check_field(string name, word_type exp_v, word_type act_v);
         if (exp_v !== act_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            errors++;
         end
      endfunction

      function void check_result(pushed_type act);
         pushed_type exp_r;
         if (pending.size() == 0) begin
            $error("response beat with nothing outstanding");
            errors++;
            return;
         end
         exp_r = pending.pop_front();
         check_field("new_vel_x", exp_r.nvx, act.nvx);
         check_field("new_vel_y", exp_r.nvy, act.nvy);
         check_field("new_vel_z", exp_r.nvz, act.nvz);
         check_field("step_x", exp_r.sx, act.sx);
         check_field("step_y", exp_r.sy, act.sy);
         check_field("step_z", exp_r.sz, act.sz);
      endfunction
   endclass

   logic                 clock;
   logic                 reset;
   logic                 csr_wr_en;
   logic                 csr_index;
   logic [WORD_BITS-1:0] csr_wdata;

   bvp_req_if #(.WORD_BITS(WORD_BITS)) req_chan ();
   bvp_rsp_if #(.WORD_BITS(WORD_BITS)) rsp_chan ();

   boris_velocity_push_core #(
      .WORD_BITS    (WORD_BITS),
      .FRACTION_BITS(FRACTION_BITS)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan),
      .csr_wr_en(csr_wr_en),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   push_scoreboard board = new();
   int             hold_request = 0;
   int             hold_left = 0;
   int             stall_mode = 0;
   int             stall_count = 0;

   always begin
      clock = 1'b1; #5;
      clock = 1'b0; #5;
   end

   always @(posedge clock) begin
      if (hold_request != 0) begin
         hold_left    = hold_request;
         hold_request = 0;
      end
      stall_count++;
      if (stall_count % 64 == 0) stall_mode = $urandom_range(0, 2);
      if (hold_left > 0) begin
         hold_left--;
         rsp_chan.ready <= 1'b0;
      end else if (stall_mode == 0) begin
         rsp_chan.ready <= 1'b1;
      end else if (stall_mode == 1) begin
         rsp_chan.ready <= 1'($urandom_range(0, 1));
      end else begin
         rsp_chan.ready <= ($urandom_range(0, 7) != 0);
      end
   end

   always @(posedge clock) begin
      particle_type pt;
      pushed_type   rs;
      if (!reset) begin
         if (req_chan.valid && req_chan.ready) begin
            pt = '{req_chan.vel_x, req_chan.vel_y, req_chan.vel_z,
                   req_chan.field_ex, req_chan.field_ey, req_chan.field_ez,
                   req_chan.field_bx, req_chan.field_by, req_chan.field_bz};
            board.note_particle(pt);
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            rs = '{rsp_chan.new_vel_x, rsp_chan.new_vel_y, rsp_chan.new_vel_z,
                   rsp_chan.step_x, rsp_chan.step_y, rsp_chan.step_z};
            board.check_result(rs);
         end
      end
   end

   function automatic word_type random_word();
      case ($urandom_range(0, 5))
         0, 1:    return $urandom;
         2:       return $signed({14'd0, 18'($urandom)}) - 32'sd131072;
         3:       return $signed({10'd0, 22'($urandom)}) - 32'sd2097152;
         4:       return $urandom_range(0, 1) ? 32'sh7fffffff : 32'sh80000000;
         default: return 32'sd0;
      endcase
   endfunction

   function automatic particle_type random_particle();
      particle_type pt;
      pt = '{random_word(), random_word(), random_word(), random_word(), random_word(),
             random_word(), random_word(), random_word(), random_word()};
      return pt;
   endfunction

   task automatic csr_write(int unsigned idx, logic [WORD_BITS-1:0] data);
      csr_wr_en <= 1'b1;
      csr_index <= idx[0];
      csr_wdata <= data;
      @(posedge clock);
      board.set_reg(idx, data);
      csr_wr_en <= 1'b0;
      @(posedge clock);
   endtask

   task automatic send_particle(particle_type pt);
      req_chan.valid    <= 1'b1;
      req_chan.vel_x    <= pt.vx;
      req_chan.vel_y    <= pt.vy;
      req_chan.vel_z    <= pt.vz;
      req_chan.field_ex <= pt.ex;
      req_chan.field_ey <= pt.ey;
      req_chan.field_ez <= pt.ez;
      req_chan.field_bx <= pt.bx;
      req_chan.field_by <= pt.by;
      req_chan.field_bz <= pt.bz;
      @(posedge clock);
      while (!req_chan.ready) @(posedge clock);
   endtask

   task automatic send_burst_stream(int count);
      int left;
      int burst;
      left = count;
      while (left > 0) begin
         burst = $urandom_range(1, 24);
         for (int i = 0; i < burst && left > 0; i++) begin
            send_particle(random_particle());
            left--;
         end
         if ($urandom_range(0, 3) != 0) begin
            req_chan.valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clock);
         end
      end
      req_chan.valid <= 1'b0;
   endtask

   task automatic drain();
      @(posedge clock);
      while (board.pending.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   initial begin
      particle_type            directed[$];
      logic [WORD_BITS-1:0]    qm_set[6];
      logic [WORD_BITS-1:0]    hd_set[6];

      reset          <= 1'b1;
      csr_wr_en      <= 1'b0;
      csr_index      <= 1'b0;
      csr_wdata      <= '0;
      req_chan.valid <= 1'b0;
      req_chan.vel_x <= '0; req_chan.vel_y <= '0; req_chan.vel_z <= '0;
      req_chan.field_ex <= '0; req_chan.field_ey <= '0; req_chan.field_ez <= '0;
      req_chan.field_bx <= '0; req_chan.field_by <= '0; req_chan.field_bz <= '0;
      repeat (5) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Registers at their reset values first, then a typical setting.
      send_particle('{9{32'sh7fffffff}});
      send_particle('{9{32'sh80000000}});
      req_chan.valid <= 1'b0;
      drain();
      csr_write(bvp_pkg::CSR_HALF_QM_DT, 32'h0000_8000);
      csr_write(bvp_pkg::CSR_HALF_DT, 32'h0000_8000);
      directed.push_back('{9{32'sd0}});
      directed.push_back('{9{32'sh7fffffff}});
      directed.push_back('{9{32'sh80000000}});
      directed.push_back('{32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                           32'sh7fffffff, 32'sh80000000, 32'sh7fffffff, 32'sh80000000,
                           32'sh7fffffff});
      directed.push_back('{32'sh00010000, 32'sh00020000, -32'sh00010000, 32'sd0, 32'sd0,
                           32'sd0, 32'sd0, 32'sd0, 32'sh00020000});
      directed.push_back('{32'sd0, 32'sd0, 32'sd0, 32'sh00010000, -32'sh00030000,
                           32'sh00000001, 32'sd0, 32'sd0, 32'sd0});
      directed.push_back('{32'sh00010000, 32'sd0, 32'sd0, 32'sd0, 32'sd0, 32'sd0,
                           32'sh7fffffff, 32'sh7fffffff, 32'sh7fffffff});
      directed.push_back('{-32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1, -32'sd1,
                           -32'sd1, -32'sd1});
      directed.push_back('{32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1, 32'sd1,
                           32'sd1});
      directed.push_back('{32'sh7fff0000, 32'sh7fff0000, 32'sh7fff0000, 32'sh7fff0000,
                           32'sh7fff0000, 32'sh7fff0000, 32'sd0, 32'sd0, 32'sd0});
      foreach (directed[i]) send_particle(directed[i]);
      req_chan.valid <= 1'b0;
      drain();

      qm_set = '{32'h0000_4000, 32'h7fff_ffff, 32'h8000_0000, 32'hffff_c000,
                 32'h0000_0001, 32'h0000_0000};
      hd_set = '{32'h0000_8000, 32'hffff_ffff, 32'h0000_0000, 32'h0000_0001,
                 32'h7fff_ffff, 32'h0000_4000};
      for (int ph = 0; ph < 6; ph++) begin
         if (ph == 5) begin
            csr_write(bvp_pkg::CSR_HALF_QM_DT, 32'($urandom_range(0, 65535)) - 32'h8000);
            csr_write(bvp_pkg::CSR_HALF_DT, $urandom);
         end else begin
            csr_write(bvp_pkg::CSR_HALF_QM_DT, qm_set[ph]);
            csr_write(bvp_pkg::CSR_HALF_DT, hd_set[ph]);
         end
         if (ph == 2) hold_request = 400;
         send_burst_stream(180);
         // The sender waits here until every outstanding beat has come back.
         drain();
      end

      fork
         begin
            while (board.pending.size() != 0) @(posedge clock);
            repeat (LATENCY + 10) @(posedge clock);
         end
         begin
            repeat (20000) @(posedge clock);
            $display("boris_velocity_push_core: mismatch");
            $finish;
         end
      join_any
      if (board.errors == 0)
         $display("boris_velocity_push_core: match");
      else
         $display("boris_velocity_push_core: mismatch");
      $finish;
   end

   initial begin
      #5ms;
      $display("boris_velocity_push_core: mismatch");
      $finish;
   end

endmodule

`default_nettype wire

[files.f]
+incdir+src
src/bvp_pkg.sv
src/bvp_if.sv
src/bvp_recip.sv
src/boris_velocity_push_core.sv
dv/testbench.sv
